FILE: rtl/rcnc_pkg.sv
// ----------------------------------------------------------------------------
// rcnc_pkg: shared types and constants for the ray/circle nearest contact block
// Holds the controller states, divider operand codes, register map and the
// command/status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rcnc_pkg;

  // Register map (word index within the configuration space)
  localparam int          ADDR_W       = 5;
  localparam logic [2:0]  REG_SHOW_ON  = 3'd0;
  localparam logic [2:0]  REG_START_X  = 3'd1;
  localparam logic [2:0]  REG_START_Y  = 3'd2;
  localparam logic [2:0]  REG_DIR_X    = 3'd3;
  localparam logic [2:0]  REG_DIR_Y    = 3'd4;
  localparam logic [2:0]  REG_LINE_A   = 3'd5;
  localparam logic [2:0]  REG_LINE_B   = 3'd6;
  localparam logic [2:0]  REG_LINE_C   = 3'd7;

  // Divider operand width and far-end length
  localparam int                 DIV_W   = 58;
  localparam logic signed [11:0] FAR_LEN = 12'sd1000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_MUL,
    ST_CHECK,
    ST_DIVX,
    ST_DIVY,
    ST_AHEAD,
    ST_AHEAD2,
    ST_DIVT,
    ST_SQRT,
    ST_CONTACT,
    ST_POINT,
    ST_DIST,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_FOOT_X,
    DIV_FOOT_Y,
    DIV_BACKOFF
  } div_sel_t;

  typedef struct packed {
    logic               show_on;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] line_a;
    logic signed [15:0] line_b;
    logic signed [31:0] line_c;
  } cfg_t;

  typedef struct packed {
    logic     ld_item;
    logic     radius_ld;
    logic     line;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_ld;
    div_sel_t div_ld_sel;
    logic     ahead;
    logic     sqrt_start;
    logic     contact;
    logic     point;
    logic     dist_ld;
    logic     update;
    logic     clear_frame;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic show_on;
    logic degen;
    logic miss;
    logic behind;
    logic div_done;
    logic div_busy;
    logic sqrt_done;
  } sts_t;

endpackage

FILE: rtl/rcnc_div.sv
// ----------------------------------------------------------------------------
// rcnc_div: shared restoring divider
// Unsigned long division, one quotient bit per cycle over the full dividend.
// ----------------------------------------------------------------------------
module rcnc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rcnc_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                 divisor,
  output logic                        busy,
  output logic                        done,
  output logic [rcnc_pkg::DIV_W-1:0]  quot
);
  import rcnc_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [31:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic             ge;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, quot[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out and quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[31:0] : trial[31:0];
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/rcnc_ctrl.sv
// ----------------------------------------------------------------------------
// rcnc_ctrl: sequencer for the nearest contact search
// Walks each circle through line test, foot point, ahead test, backoff and
// distance compare, and hands the frame result to the output register.
// ----------------------------------------------------------------------------
module rcnc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                is_cue,
  input  logic                last,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rcnc_pkg::sts_t      sts,
  output rcnc_pkg::cmd_t      cmd
);
  import rcnc_pkg::*;

  state_t state, state_next;
  logic   last_flag;
  state_t frame_end;

  // State register and frame marker
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_item) begin
        last_flag <= last;
      end
    end
  end

  // Output word valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != ST_IDLE);
    frame_end  = last_flag ? ST_FINISH : ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          if (!sts.show_on) begin
            cmd.clear_frame = last;
          end else if (!is_cue && !sts.degen) begin
            state_next = ST_LINE;
          end else if (last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LINE: begin
        cmd.line      = 1'b1;
        cmd.radius_ld = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.miss) begin
          state_next = frame_end;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_FOOT_X;
          state_next    = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (sts.div_done) begin
          cmd.div_ld     = 1'b1;
          cmd.div_ld_sel = DIV_FOOT_X;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = DIV_FOOT_Y;
          state_next     = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (sts.div_done) begin
          cmd.div_ld     = 1'b1;
          cmd.div_ld_sel = DIV_FOOT_Y;
          state_next     = ST_AHEAD;
        end
      end
      ST_AHEAD: begin
        cmd.ahead  = 1'b1;
        state_next = ST_AHEAD2;
      end
      ST_AHEAD2: begin
        if (sts.behind) begin
          state_next = frame_end;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_BACKOFF;
          state_next    = ST_DIVT;
        end
      end
      ST_DIVT: begin
        if (sts.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          state_next = ST_CONTACT;
        end
      end
      ST_CONTACT: begin
        cmd.contact = 1'b1;
        state_next  = ST_POINT;
      end
      ST_POINT: begin
        cmd.point  = 1'b1;
        state_next = ST_DIST;
      end
      ST_DIST: begin
        cmd.dist_ld = 1'b1;
        state_next  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = frame_end;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.ld_out      = 1'b1;
          cmd.clear_frame = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rcnc_dp.sv
// ----------------------------------------------------------------------------
// rcnc_dp: datapath for the nearest contact search
// Line distance, foot point, ahead test, backoff square root, contact point,
// squared distance, best-contact keeping and the output word register.
// ----------------------------------------------------------------------------
module rcnc_dp (
  input  logic                clk,
  input  logic                rst,
  input  rcnc_pkg::cfg_t      cfg,
  input  rcnc_pkg::cmd_t      cmd,
  output rcnc_pkg::sts_t      sts,
  input  logic signed [15:0]  ball_x,
  input  logic signed [15:0]  ball_y,
  input  logic [11:0]         ball_r,
  output logic                hit,
  output logic signed [15:0]  end_x,
  output logic signed [15:0]  end_y,
  output logic [11:0]         circle_radius
);
  import rcnc_pkg::*;

  // Round a Q14 product to nearest, halves away from zero
  function automatic logic signed [36:0] rnd14(input logic signed [29:0] v);
    logic [29:0] mag;
    logic [15:0] m;
    mag = v[29] ? 30'(-v) : 30'(v);
    m = 16'((mag + 30'd8192) >> 14);
    rnd14 = v[29] ? -37'(m) : 37'(m);
  endfunction

  // Round a Q10 product to nearest, halves away from zero
  function automatic logic signed [36:0] rnd10(input logic signed [27:0] v);
    logic [27:0] mag;
    logic [17:0] m;
    mag = v[27] ? 28'(-v) : 28'(v);
    m = 18'((mag + 28'd512) >> 10);
    rnd10 = v[27] ? -37'(m) : 37'(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    if (v > 37'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -37'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  logic signed [15:0] bx, by;
  logic [11:0]        br;
  logic signed [33:0] lval;
  logic [31:0]        nval;
  logic [23:0]        rsq;
  logic [63:0]        l2;
  logic [57:0]        lim;
  logic signed [49:0] al, bl;
  logic signed [35:0] fx, fy;
  logic signed [52:0] pa, pb;
  logic [25:0]        sq_v;
  logic [26:0]        sq_r;
  logic [24:0]        sq_bit;
  logic               sq_run, sq_done;
  logic signed [29:0] dxt, dyt;
  logic signed [15:0] px, py;
  logic [33:0]        cand_dist, best_dist;
  logic signed [15:0] best_x, best_y;
  logic               any_hit;
  logic [11:0]        last_radius;

  logic signed [31:0] m_ax, m_by, m_aa, m_bb;
  logic signed [33:0] lval_next;
  logic [31:0]        nval_next;
  logic [33:0]        lmag;
  logic [65:0]        l2_full;
  logic [55:0]        rn;
  logic signed [49:0] al_next, bl_next;
  logic [49:0]        mag_al, mag_bl;
  logic [63:0]        slack;
  logic [DIV_W-1:0]   div_dividend, div_quot;
  logic               div_busy, div_done;
  logic signed [35:0] q_foot;
  logic signed [36:0] dfx, dfy;
  logic signed [53:0] ahead_sum;
  logic [26:0]        sq_sum;
  logic signed [16:0] ddx, ddy;
  logic signed [33:0] sqx, sqy;
  logic [33:0]        dist_next;
  logic signed [27:0] far_mx, far_my;
  logic signed [15:0] far_x, far_y;

  // Arithmetic for each stage
  always_comb begin
    m_ax      = $signed(cfg.line_a) * bx;
    m_by      = $signed(cfg.line_b) * by;
    m_aa      = $signed(cfg.line_a) * $signed(cfg.line_a);
    m_bb      = $signed(cfg.line_b) * $signed(cfg.line_b);
    lval_next = 34'(m_ax) + 34'(m_by) + 34'($signed(cfg.line_c));
    nval_next = m_aa + m_bb;

    lmag    = lval[33] ? 34'(-lval) : 34'(lval);
    l2_full = lmag[32:0] * lmag[32:0];
    rn      = rsq * nval;
    al_next = $signed(cfg.line_a) * lval;
    bl_next = $signed(cfg.line_b) * lval;

    mag_al = al[49] ? 50'(-al) : 50'(al);
    mag_bl = bl[49] ? 50'(-bl) : 50'(bl);
    slack  = {6'd0, lim} - l2;
    case (cmd.div_sel)
      DIV_FOOT_X:  div_dividend = 58'(mag_al) + 58'(nval[31:1]);
      DIV_FOOT_Y:  div_dividend = 58'(mag_bl) + 58'(nval[31:1]);
      DIV_BACKOFF: div_dividend = slack[57:0];
      default:     div_dividend = '0;
    endcase
    q_foot = $signed({2'b00, div_quot[33:0]});

    dfx       = 37'(fx) - 37'($signed(cfg.start_x));
    dfy       = 37'(fy) - 37'($signed(cfg.start_y));
    ahead_sum = 54'(pa) + 54'(pb);

    sq_sum = sq_r + 27'(sq_bit);

    ddx       = 17'(px) - 17'($signed(cfg.start_x));
    ddy       = 17'(py) - 17'($signed(cfg.start_y));
    sqx       = ddx * ddx;
    sqy       = ddy * ddy;
    dist_next = sqx + sqy;

    far_mx = $signed(cfg.dir_x) * FAR_LEN;
    far_my = $signed(cfg.dir_y) * FAR_LEN;
    far_x  = sat16(37'($signed(cfg.start_x)) + rnd10(far_mx));
    far_y  = sat16(37'($signed(cfg.start_y)) + rnd10(far_my));
  end

  always_comb begin
    sts.show_on   = cfg.show_on;
    sts.degen     = (cfg.line_a == '0) && (cfg.line_b == '0);
    sts.miss      = l2 > {6'd0, lim};
    sts.behind    = ahead_sum[53];
    sts.div_done  = div_done;
    sts.div_busy  = div_busy;
    sts.sqrt_done = sq_done;
  end

  rcnc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (nval),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Stage registers of the circle test
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      bx <= ball_x;
      by <= ball_y;
      br <= ball_r;
    end
    if (cmd.line) begin
      lval <= lval_next;
      nval <= nval_next;
      rsq  <= br * br;
    end
    if (cmd.mul) begin
      l2  <= l2_full[63:0];
      lim <= {rn, 2'b00};
      al  <= al_next;
      bl  <= bl_next;
    end
    if (cmd.div_ld) begin
      case (cmd.div_ld_sel)
        DIV_FOOT_X: fx <= 36'(bx) - (al[49] ? -q_foot : q_foot);
        DIV_FOOT_Y: fy <= 36'(by) - (bl[49] ? -q_foot : q_foot);
        default: ;
      endcase
    end
    if (cmd.ahead) begin
      pa <= dfx * $signed(cfg.dir_x);
      pb <= dfy * $signed(cfg.dir_y);
    end
    if (cmd.contact) begin
      dxt <= $signed(cfg.dir_x) * $signed({1'b0, sq_r[12:0]});
      dyt <= $signed(cfg.dir_y) * $signed({1'b0, sq_r[12:0]});
    end
    if (cmd.point) begin
      px <= sat16(37'(fx) - rnd14(dxt));
      py <= sat16(37'(fy) - rnd14(dyt));
    end
    if (cmd.dist_ld) begin
      cand_dist <= dist_next;
    end
  end

  // Square root, one result bit per step from two bits of radicand
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_run  <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_run <= 1'b1;
      end else if (sq_run && sq_bit[0]) begin
        sq_run  <= 1'b0;
        sq_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_v   <= div_quot[25:0];
      sq_r   <= '0;
      sq_bit <= {1'b1, 24'd0};
    end else if (sq_run) begin
      if (27'(sq_v) >= sq_sum) begin
        sq_v <= sq_v - sq_sum[25:0];
        sq_r <= (sq_r >> 1) + 27'(sq_bit);
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // Keep the nearest contact; clear at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit     <= 1'b0;
      best_dist   <= '0;
      best_x      <= '0;
      best_y      <= '0;
      last_radius <= '0;
    end else begin
      if (cmd.radius_ld) begin
        last_radius <= br;
      end
      if (cmd.clear_frame) begin
        any_hit   <= 1'b0;
        best_dist <= '0;
        best_x    <= '0;
        best_y    <= '0;
      end else if (cmd.update && (!any_hit || cand_dist < best_dist)) begin
        any_hit   <= 1'b1;
        best_dist <= cand_dist;
        best_x    <= px;
        best_y    <= py;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      hit           <= any_hit;
      end_x         <= any_hit ? best_x : far_x;
      end_y         <= any_hit ? best_y : far_y;
      circle_radius <= last_radius;
    end
  end

endmodule

FILE: rtl/ray_circle_nearest_contact_top.sv
// ----------------------------------------------------------------------------
// ray_circle_nearest_contact_top: nearest contact of a ray against circles
// Register port, controller and datapath of the nearest contact search.
// ----------------------------------------------------------------------------
// A skipped circle or one off the line uses no division; a circle that
// reaches the backoff uses three divisions on the shared divider plus a
// 13-step square root. Throughput: one circle at a time; the frame word is
// loaded after the marked circle finishes, once no held word is stalled.
// Reset clears the configuration, controller, frame and output valid flag.
module ray_circle_nearest_contact_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcnc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            ball_x,
  input  logic signed [15:0]            ball_y,
  input  logic [11:0]                   ball_r,
  input  logic                          is_cue,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic signed [15:0]            end_x,
  output logic signed [15:0]            end_y,
  output logic [11:0]                   circle_radius
);
  import rcnc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SHOW_ON: cfg.show_on <= pwdata[0];
        REG_START_X: cfg.start_x <= pwdata[15:0];
        REG_START_Y: cfg.start_y <= pwdata[15:0];
        REG_DIR_X:   cfg.dir_x   <= pwdata[15:0];
        REG_DIR_Y:   cfg.dir_y   <= pwdata[15:0];
        REG_LINE_A:  cfg.line_a  <= pwdata[15:0];
        REG_LINE_B:  cfg.line_b  <= pwdata[15:0];
        REG_LINE_C:  cfg.line_c  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads, signed fields sign extended
  always_comb begin
    case (paddr[4:2])
      REG_SHOW_ON: prdata = {31'd0, cfg.show_on};
      REG_START_X: prdata = {{16{cfg.start_x[15]}}, cfg.start_x};
      REG_START_Y: prdata = {{16{cfg.start_y[15]}}, cfg.start_y};
      REG_DIR_X:   prdata = {{16{cfg.dir_x[15]}}, cfg.dir_x};
      REG_DIR_Y:   prdata = {{16{cfg.dir_y[15]}}, cfg.dir_y};
      REG_LINE_A:  prdata = {{16{cfg.line_a[15]}}, cfg.line_a};
      REG_LINE_B:  prdata = {{16{cfg.line_b[15]}}, cfg.line_b};
      REG_LINE_C:  prdata = cfg.line_c;
      default:     prdata = '0;
    endcase
  end

  rcnc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_cue    (is_cue),
    .last      (last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcnc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .ball_x        (ball_x),
    .ball_y        (ball_y),
    .ball_r        (ball_r),
    .hit           (hit),
    .end_x         (end_x),
    .end_y         (end_y),
    .circle_radius (circle_radius)
  );

  // The divider is never left running while a new word is taken
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !sts.div_busy)
    else $error("divider busy while accepting a word");

  // A result is never loaded over a word that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> (!out_valid || !out_stall))
    else $error("output word overwritten");

  // A word taken while disabled never leads straight to a result
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !cfg.show_on) |=> !cmd.ld_out)
    else $error("result loaded while disabled");

endmodule
